### rtl/bitmap_slab_allocator_macros.svh
`ifndef BITMAP_SLAB_ALLOCATOR_MACROS_SVH
`define BITMAP_SLAB_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bsa_pkg.sv
package bsa_pkg;

    localparam int MAX_SLOTS  = 512;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W     = 64;
    localparam int PAGE_W     = 52;
    localparam int SIZE_W     = 12;
    localparam int COUNT_W    = 10;
    localparam int DOFF_W     = 12;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_LSB    = 3;
    localparam int CFG_ADDR_W = CFG_LSB + 2;

    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int ROW_W       = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
    localparam int BIT_W       = $clog2(ROW_W);
    localparam int ROWS        = (MAX_SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int LIM_W       = (SLOT_CNT_W > COUNT_W) ? SLOT_CNT_W : COUNT_W;
    localparam int OFF_W       = PAGE_SHIFT;
    localparam int CMP_W       = (LIM_W > OFF_W) ? LIM_W : OFF_W;
    localparam int PROD_W      = SIZE_W + SLOT_W;
    localparam int PN_CMP_W    = ADDR_W - PAGE_SHIFT;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_PAGE_NUMBER  = 2'd0,
        REG_OBJECT_SIZE  = 2'd1,
        REG_OBJECT_COUNT = 2'd2,
        REG_DATA_OFFSET  = 2'd3
    } reg_idx_t;

endpackage

### rtl/bsa_if.sv
interface bsa_req_if;
    logic                        valid;
    logic                        ready;
    bsa_pkg::op_t                op;
    logic [bsa_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output op, output address, input ready);
    modport sink   (input valid, input op, input address, output ready);
endinterface

interface bsa_rsp_if;
    logic                        valid;
    logic                        ready;
    bsa_pkg::status_t            status;
    logic [bsa_pkg::ADDR_W-1:0]  object_address;
    logic                        busy_res;

    modport source (output valid, output status, output object_address, output busy_res,
                    input ready);
    modport sink   (input valid, input status, input object_address, input busy_res,
                    output ready);
endinterface

### rtl/bitmap_slab_allocator.sv
// Allocate: the bitmap is scanned one 32-slot row per cycle from its registered-read memory;
//   a hit then passes S_MUL and S_ADD, a full bitmap goes straight to S_DONE.
// Free: a failed page, offset or size check goes straight to S_DONE; else the 12-step
//   divider runs, then S_FBIT, or S_DONE on a slot out of range; S_DONE waits on the output register.
// One item at a time: the next transfer is taken the cycle after the result is loaded.
// Reset: asynchronous; per-row valid bits make every slot read as free, with no clearing pass.
`include "bitmap_slab_allocator_macros.svh"

module bitmap_slab_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    bsa_req_if.sink                        req,
    bsa_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bsa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bsa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ADD  = 8'b0000_1000,
        S_FCHK = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FBIT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [PAGE_W-1:0]  page_number_reg;
    logic [SIZE_W-1:0]  object_size_reg;
    logic [COUNT_W-1:0] object_count_reg;
    logic [DOFF_W-1:0]  data_offset_reg;
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    op_t                op_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [ROW_IDX_W-1:0] row_reg, row_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [PROD_W-1:0]  prod_reg;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  obj_addr_reg, obj_addr_next;
    logic               full_flag_reg, full_flag_next;
    logic               req_ready;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic               out_busy_reg;
    logic               out_load;

    logic [ROW_W-1:0]     bitmap_mem [ROWS];
    logic [ROWS-1:0]      row_valid_reg;
    logic [ROW_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;
    logic [ROW_IDX_W-1:0] rd_addr;
    logic                 mem_we;
    logic [ROW_IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0]     wr_data;

    logic                 div_start;
    logic [OFF_W-1:0]     div_dividend;
    logic                 div_done;
    logic [OFF_W-1:0]     div_quotient;

    logic [LIM_W-1:0]     count_ext;
    logic [LIM_W-1:0]     limit;
    logic [ROW_W-1:0]     row_eff;
    logic [LIM_W-1:0]     row_base;
    logic [LIM_W-1:0]     rem_slots;
    logic [ROW_W-1:0]     free_vec;
    logic                 hit;
    logic [BIT_W-1:0]     hit_bit;
    logic                 scan_last;
    logic [SLOT_W-1:0]    scan_slot;
    logic [ADDR_W-1:0]    base_or;

    logic                 page_match;
    logic [OFF_W-1:0]     offset;
    logic [OFF_W-1:0]     doff_ext;
    logic                 free_ok;
    logic                 quot_in_range;
    logic [SLOT_W-1:0]    quot_slot;
    logic [ROW_IDX_W-1:0] quot_row;
    logic [BIT_W-1:0]     fbit;
    logic [ROW_IDX_W-1:0] frow;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_number_reg  <= '0;
            object_size_reg  <= SIZE_W'(32);
            object_count_reg <= COUNT_W'(1);
            data_offset_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_PAGE_NUMBER:  page_number_reg  <= pwdata[PAGE_W-1:0];
                REG_OBJECT_SIZE:  object_size_reg  <= pwdata[SIZE_W-1:0];
                REG_OBJECT_COUNT: object_count_reg <= pwdata[COUNT_W-1:0];
                REG_DATA_OFFSET:  data_offset_reg  <= pwdata[DOFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PAGE_NUMBER:  prdata = CFG_DATA_W'(page_number_reg);
            REG_OBJECT_SIZE:  prdata = CFG_DATA_W'(object_size_reg);
            REG_OBJECT_COUNT: prdata = CFG_DATA_W'(object_count_reg);
            REG_DATA_OFFSET:  prdata = CFG_DATA_W'(data_offset_reg);
            default:          prdata = '0;
        endcase
    end

    // Used bitmap, one row per word; a row never written reads as all free
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= bitmap_mem[rd_addr];
        rd_valid_reg <= row_valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (mem_we)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign row_eff = rd_valid_reg ? rd_data_reg : '0;

    // Row scan for the lowest free slot below the limit
    assign count_ext = LIM_W'(object_count_reg);
    assign limit     = (count_ext > LIM_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS) : count_ext;
    assign row_base  = LIM_W'(row_reg) << BIT_W;
    assign rem_slots = (limit > row_base) ? (limit - row_base) : '0;
    assign scan_last = (row_reg == ROW_IDX_W'(ROWS - 1)) || (rem_slots <= LIM_W'(ROW_W));
    assign scan_slot = SLOT_W'({row_reg, hit_bit});

    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            free_vec[b] = !row_eff[b] && (rem_slots > LIM_W'(b));
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (free_vec[b])
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(b);
            end
        end
    end

    // Base and data offset never overlap, so OR them
    assign base_or = (ADDR_W'(page_number_reg) << PAGE_SHIFT) | ADDR_W'(data_offset_reg);

    // Free path checks
    assign page_match    = address_reg[ADDR_W-1:PAGE_SHIFT] == page_number_reg[PN_CMP_W-1:0];
    assign offset        = address_reg[OFF_W-1:0];
    assign doff_ext      = OFF_W'(data_offset_reg);
    assign free_ok       = page_match && (offset >= doff_ext) && (object_size_reg != '0);
    assign div_dividend  = offset - doff_ext;
    assign quot_in_range = CMP_W'(div_quotient) < CMP_W'(limit);
    assign quot_slot     = div_quotient[SLOT_W-1:0];
    assign quot_row      = ROW_IDX_W'(quot_slot >> BIT_W);
    assign fbit          = slot_reg[BIT_W-1:0];
    assign frow          = ROW_IDX_W'(slot_reg >> BIT_W);

    bsa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (object_size_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        obj_addr_next  = obj_addr_reg;
        full_flag_next = full_flag_reg;
        req_ready      = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = row_reg;
        wr_data        = row_eff;
        rd_addr        = row_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                rd_addr   = '0;
                if (req.valid)
                begin
                    row_next      = '0;
                    status_next   = ST_OK;
                    obj_addr_next = '0;
                    state_next    = (req.op == OP_ALLOC) ? S_SCAN : S_FCHK;
                end
            end
            S_SCAN:
            begin
                rd_addr = row_reg + ROW_IDX_W'(1);
                if (hit)
                begin
                    mem_we     = 1'b1;
                    wr_data    = row_eff | (ROW_W'(1) << hit_bit);
                    slot_next  = scan_slot;
                    state_next = S_MUL;
                end
                else if (scan_last)
                begin
                    status_next    = ST_FULL;
                    full_flag_next = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    row_next = row_reg + ROW_IDX_W'(1);
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                obj_addr_next = base_or + ADDR_W'(prod_reg);
                state_next    = S_DONE;
            end
            S_FCHK:
            begin
                if (free_ok)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
            end
            S_DIV:
            begin
                rd_addr = quot_row;
                if (div_done)
                begin
                    slot_next = quot_slot;
                    if (quot_in_range)
                    begin
                        state_next = S_FBIT;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_FBIT:
            begin
                if (!row_eff[fbit])
                begin
                    status_next = ST_FREE;
                end
                else
                begin
                    mem_we         = 1'b1;
                    wr_addr        = frow;
                    wr_data        = row_eff & ~(ROW_W'(1) << fbit);
                    full_flag_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            full_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            full_flag_reg <= full_flag_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        obj_addr_reg <= obj_addr_next;
        if (req.valid && req_ready)
        begin
            op_reg      <= req.op;
            address_reg <= req.address;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(object_size_reg) * PROD_W'(slot_reg);
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_addr_reg   <= obj_addr_reg;
            out_busy_reg   <= full_flag_reg;
        end
    end

    assign req.ready          = req_ready;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.object_address = out_addr_reg;
    assign rsp.busy_res       = out_busy_reg;

    `BSA_ASSERT_SAME(a_fail_zero_addr, out_valid_reg && (out_status_reg != ST_OK),
                     out_addr_reg == '0, "failed or free result carries an address")
    `BSA_ASSERT_SAME(a_full_sets_busy, out_valid_reg && (out_status_reg == ST_FULL),
                     out_busy_reg, "full result without busy flag")
    `BSA_ASSERT_SAME(a_write_state, mem_we,
                     (state_reg == S_SCAN) || (state_reg == S_FBIT), "bitmap write out of turn")
    `BSA_ASSERT_NEXT(a_div_follow, div_start && (op_reg == OP_FREE),
                     state_reg == S_DIV, "divider started without waiting for it")
    `BSA_ASSERT_SAME(a_div_done_state, div_done,
                     state_reg == S_DIV, "divider finished outside its wait state")

endmodule

### rtl/bsa_divider.sv
module bsa_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bsa_pkg::OFF_W-1:0]  dividend,
    input  logic [bsa_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [bsa_pkg::OFF_W-1:0]  quotient
);
    import bsa_pkg::*;

    localparam int CNT_W = $clog2(OFF_W + 1);

    logic [CNT_W-1:0]  count_reg;
    logic              done_reg;
    logic [OFF_W-1:0]  quot_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] divisor_reg;
    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   trial;

    // One quotient bit per cycle, restoring form
    assign shifted = {rem_reg, quot_reg[OFF_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                count_reg <= CNT_W'(OFF_W);
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            if (!trial[SIZE_W])
            begin
                rem_reg  <= trial[SIZE_W-1:0];
                quot_reg <= {quot_reg[OFF_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[SIZE_W-1:0];
                quot_reg <= {quot_reg[OFF_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
